// ===== design/mwe_pkg.sv =====
package mwe_pkg;

	localparam int WORD_COUNT = 64;
	localparam int WORD_BITS  = 16;
	localparam int ADDR_W     = $clog2(WORD_COUNT);
	localparam int CNT_W      = 5;

	localparam logic [WORD_BITS-1:0] ERASED_WORD = '1;

	// item kinds carried on the slave tuser
	typedef enum logic [1:0] {
		CMD_PINS   = 2'd0,
		CMD_STATUS = 2'd1,
		CMD_CTRL   = 2'd2
	} cmd_t;

	// protocol phase of the emulated part
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_OPCODE = 2'd1,
		PH_READ   = 2'd2,
		PH_WRITE  = 2'd3
	} phase_t;

	// top two opcode bits
	localparam logic [1:0] OP_SPECIAL = 2'b00;
	localparam logic [1:0] OP_WRITE   = 2'b01;
	localparam logic [1:0] OP_READ    = 2'b10;
	localparam logic [1:0] OP_ERASE   = 2'b11;

	// opcode bits 5:4 of the special group
	localparam logic [1:0] SP_EWDS = 2'b00;
	localparam logic [1:0] SP_WRAL = 2'b01;
	localparam logic [1:0] SP_ERAL = 2'b10;
	localparam logic [1:0] SP_EWEN = 2'b11;

	// pin line bit positions
	localparam int PIN_DI  = 0;
	localparam int PIN_CLK = 1;
	localparam int PIN_CS  = 2;
	localparam int PIN_DO  = 3;

	// control byte bits
	localparam int CTRL_RESET  = 7;
	localparam int CTRL_ENABLE = 3;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic commit;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

// ===== design/mwe_ram.sv =====
module mwe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/mwe_ctrl.sv =====
module mwe_ctrl import mwe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output ctl_t  ctl
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q, state_n;

	assign s_tready = (state_q == S_IDLE);

	// item flow: take item, read word, apply update when output slot is free
	always_comb begin
		state_n    = state_q;
		ctl.load   = 1'b0;
		ctl.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					ctl.load = 1'b1;
					state_n  = S_FETCH;
				end
			end
			S_FETCH: begin
				state_n = S_EXEC;
			end
			S_EXEC: begin
				if (stat.out_free) begin
					ctl.commit = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

// ===== design/mwe_dp.sv =====
module mwe_dp import mwe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_t       ctl,
	output stat_t      stat,
	input  logic [7:0] s_tdata,
	input  logic [1:0] s_tuser,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata
);

	// captured item
	cmd_t       cmd_q;
	logic [7:0] val_q;

	// emulated part state
	phase_t                 phase_q, phase_n;
	logic [7:0]             op_q, op_n;
	logic [CNT_W-1:0]       cnt_q, cnt_n;
	logic [WORD_BITS-1:0]   latch_q, latch_n;
	logic                   wp_q, wp_n;
	logic [3:0]             pins_q, pins_n;
	logic                   en_q, en_n;

	// words not written since the last bulk fill read as fill_q
	logic [WORD_BITS-1:0]   fill_q, fill_n;
	logic [WORD_COUNT-1:0]  valid_q;
	logic                   clr_valid;

	// memory port
	logic                   we;
	logic [ADDR_W-1:0]      waddr;
	logic [WORD_BITS-1:0]   wdata;
	logic [WORD_BITS-1:0]   rdata;
	logic [WORD_BITS-1:0]   word;

	// output register
	logic                   m_valid_q;
	logic [7:0]             m_data_q;

	logic                   din;
	logic [CNT_W-1:0]       cnt_inc;
	logic [7:0]             op_sh;
	logic [WORD_BITS-1:0]   latch_sh;

	mwe_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(op_q[ADDR_W-1:0]),
		.rdata(rdata)
	);

	assign word     = valid_q[op_q[ADDR_W-1:0]] ? rdata : fill_q;
	assign din      = val_q[PIN_DI];
	assign cnt_inc  = cnt_q + 1'b1;
	assign op_sh    = {op_q[6:0], din};
	assign latch_sh = {latch_q[WORD_BITS-2:0], din};

	// next state for one item
	always_comb begin
		phase_n   = phase_q;
		op_n      = op_q;
		cnt_n     = cnt_q;
		latch_n   = latch_q;
		wp_n      = wp_q;
		pins_n    = pins_q;
		en_n      = en_q;
		fill_n    = fill_q;
		clr_valid = 1'b0;
		we        = 1'b0;
		waddr     = op_q[ADDR_W-1:0];
		wdata     = ERASED_WORD;
		case (cmd_q)
			CMD_PINS: begin
				if (!val_q[PIN_CS]) begin
					// chip select low aborts the command
					if (pins_q[PIN_CS]) begin
						phase_n = PH_IDLE;
						op_n    = '0;
						cnt_n   = '0;
					end
					pins_n = {1'b1, val_q[2:0]};
				end else if (val_q[PIN_CLK] && !pins_q[PIN_CLK]) begin
					pins_n = {pins_q[PIN_DO], val_q[2:0]};
					unique case (phase_q)
						PH_IDLE: begin
							if (din) begin
								phase_n = PH_OPCODE;
								op_n    = '0;
								cnt_n   = '0;
							end
						end
						PH_OPCODE: begin
							op_n  = op_sh;
							cnt_n = cnt_inc;
							if (cnt_inc == CNT_W'(8)) begin
								unique case (op_sh[7:6])
									OP_SPECIAL: begin
										unique case (op_sh[5:4])
											SP_EWDS: begin
												wp_n    = 1'b1;
												phase_n = PH_IDLE;
											end
											SP_WRAL: begin
												cnt_n   = '0;
												latch_n = '0;
												phase_n = PH_WRITE;
											end
											SP_ERAL: begin
												if (!wp_q) begin
													fill_n    = ERASED_WORD;
													clr_valid = 1'b1;
												end
												pins_n[PIN_DO] = 1'b1;
												phase_n        = PH_IDLE;
											end
											SP_EWEN: begin
												wp_n    = 1'b0;
												phase_n = PH_IDLE;
											end
											default: begin
												phase_n = PH_IDLE;
											end
										endcase
									end
									OP_WRITE: begin
										cnt_n   = '0;
										latch_n = '0;
										phase_n = PH_WRITE;
									end
									OP_READ: begin
										cnt_n          = '0;
										phase_n        = PH_READ;
										pins_n[PIN_DO] = 1'b0;
									end
									OP_ERASE: begin
										// protected erase just drops back to idle
										if (!wp_q) begin
											we             = 1'b1;
											waddr          = op_sh[ADDR_W-1:0];
											wdata          = ERASED_WORD;
											pins_n[PIN_DO] = 1'b1;
										end
										phase_n = PH_IDLE;
									end
									default: begin
										phase_n = PH_IDLE;
									end
								endcase
							end
						end
						PH_READ: begin
							// msb first, then step to the next word
							pins_n[PIN_DO] = word[~cnt_q[3:0]];
							cnt_n          = cnt_inc;
							if (cnt_inc[CNT_W-1]) begin
								cnt_n = '0;
								op_n  = {2'b10, op_q[ADDR_W-1:0] + 1'b1};
							end
						end
						PH_WRITE: begin
							latch_n = latch_sh;
							cnt_n   = cnt_inc;
							if (cnt_inc[CNT_W-1]) begin
								if (!wp_q) begin
									if (op_q[6]) begin
										we    = 1'b1;
										wdata = latch_sh;
									end else begin
										fill_n    = latch_sh;
										clr_valid = 1'b1;
									end
								end
								pins_n[PIN_DO] = 1'b1;
								phase_n        = PH_IDLE;
							end
						end
						default: begin
							phase_n = PH_IDLE;
						end
					endcase
				end else begin
					pins_n = {pins_q[PIN_DO], val_q[2:0]};
				end
			end
			CMD_CTRL: begin
				if (val_q[CTRL_RESET]) begin
					en_n    = 1'b0;
					pins_n  = 4'b1000;
					wp_n    = 1'b1;
					phase_n = PH_IDLE;
					op_n    = '0;
					cnt_n   = '0;
				end else begin
					en_n = val_q[CTRL_ENABLE];
				end
			end
			default: begin
			end
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_t'(s_tuser);
			val_q <= s_tdata;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q    <= '0;
			cnt_q   <= '0;
			latch_q <= '0;
			wp_q    <= 1'b1;
			pins_q  <= 4'b1000;
			en_q    <= 1'b0;
			fill_q  <= ERASED_WORD;
			valid_q <= '0;
		end else if (ctl.commit) begin
			phase_q <= phase_n;
			op_q    <= op_n;
			cnt_q   <= cnt_n;
			latch_q <= latch_n;
			wp_q    <= wp_n;
			pins_q  <= pins_n;
			en_q    <= en_n;
			fill_q  <= fill_n;
			if (clr_valid) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	// result item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			m_data_q <= {4'b0000, en_n, pins_n[PIN_CS], 1'b1, pins_n[PIN_DO]};
		end
	end

	assign stat.out_free = !m_valid_q || m_tready;
	assign m_tvalid      = m_valid_q;
	assign m_tdata       = m_data_q;

endmodule

// ===== design/microwire_serial_eeprom_64x16.sv =====
// channel   dir  tdata                        tuser
// s_axis    in   [7:0] value                  [1:0] cmd
// m_axis    out  [2:0] pin_status, [3] enabled -
//
// each item goes through capture, word read and update in turn; the word read is
// set by the registered read port of the 64x16 word memory
// a result waits in the output register; the next item is taken meanwhile
// and its update stalls only while that register is still full
// reset brings the part to idle, protected, all words erased, no clearing pass
module microwire_serial_eeprom_64x16 import mwe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] value
	input  logic [1:0] s_tuser,  // [1:0] cmd
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [2:0] pin_status, [3] enabled, [7:4] zero
);

	ctl_t  ctl;
	stat_t stat;

	mwe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.ctl     (ctl)
	);

	mwe_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

// ===== design/mwe_chk.sv =====
module mwe_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// status bit 1 always reads back high, upper bits are padding
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1] && m_tdata[7:4] == 4'b0000))
		else $error("malformed status item");

	// data out is high whenever chip select is low
	a_do_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[2]) |-> m_tdata[0])
		else $error("data out low with chip select low");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item taken while previous one in work");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result item dropped or changed under stall");

endmodule

bind microwire_serial_eeprom_64x16 mwe_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ===== tb/tb.sv =====
module tb;
	import mwe_pkg::*;

	localparam int ITEM_GOAL   = 1500;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 100;
	localparam int PLAN_ROWS   = 19;

	// one result item as it sits in m_tdata[3:0]
	typedef struct packed {
		logic       enabled;
		logic [2:0] pin_status;
	} eep_result_t;

	// one row of the directed part
	typedef struct packed {
		cmd_t        c;
		logic [7:0]  v;
		logic        typed;
		eep_result_t want;
	} plan_row_t;

	// bus commands issued by the random part
	typedef enum int {
		MW_READ  = 0,
		MW_WRITE = 1,
		MW_ERASE = 2,
		MW_EWEN  = 3,
		MW_EWDS  = 4,
		MW_WRAL  = 5,
		MW_ERAL  = 6
	} mw_op_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	// predictor state of the emulated part
	phase_t                eep_phase;
	logic [7:0]            op_bits;
	logic [CNT_W-1:0]      bit_cnt;
	logic [WORD_BITS-1:0]  in_word;
	logic                  protect;
	logic [3:0]            lines;
	logic                  en_q;
	logic [WORD_BITS-1:0]  words [WORD_COUNT];

	eep_result_t pending [$];
	plan_row_t   plan [PLAN_ROWS];

	int  items_sent = 0;
	int  results_seen = 0;
	int  err_count = 0;
	int  quiet = 0;
	int  stall_left = 0;
	int  op_count [7];
	bit  idle_mix = 1'b1;
	bit  calm = 1'b0;

	microwire_serial_eeprom_64x16 uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void model_restart();
		eep_phase = PH_IDLE;
		op_bits   = '0;
		bit_cnt   = '0;
	endfunction

	function automatic void fill_words(logic [WORD_BITS-1:0] w);
		for (int i = 0; i < WORD_COUNT; i++)
			words[i] = w;
	endfunction

	// next state and status of the part for one item
	function automatic eep_result_t model_item(cmd_t c, logic [7:0] v);
		eep_result_t r;
		logic        din;
		din = v[PIN_DI];
		if (c == CMD_PINS) begin
			if (!v[PIN_CS]) begin
				// chip select low: restart on a falling select, data out reads ready
				if (lines[PIN_CS])
					model_restart();
				lines[2:0] = v[2:0];
				lines[PIN_DO] = 1'b1;
			end else if (v[PIN_CLK] && !lines[PIN_CLK]) begin
				lines[2:0] = v[2:0];
				case (eep_phase)
					PH_IDLE: begin
						if (din) begin
							eep_phase = PH_OPCODE;
							op_bits   = '0;
							bit_cnt   = '0;
						end
					end
					PH_OPCODE: begin
						op_bits = {op_bits[6:0], din};
						bit_cnt = bit_cnt + 1'b1;
						if (bit_cnt == 5'd8) begin
							case (op_bits[7:6])
								OP_SPECIAL: begin
									case (op_bits[5:4])
										SP_EWDS: begin
											protect   = 1'b1;
											eep_phase = PH_IDLE;
										end
										SP_WRAL: begin
											bit_cnt   = '0;
											in_word   = '0;
											eep_phase = PH_WRITE;
										end
										SP_ERAL: begin
											if (!protect)
												fill_words(ERASED_WORD);
											lines[PIN_DO] = 1'b1;
											eep_phase = PH_IDLE;
										end
										default: begin
											protect   = 1'b0;
											eep_phase = PH_IDLE;
										end
									endcase
								end
								OP_WRITE: begin
									bit_cnt   = '0;
									in_word   = '0;
									eep_phase = PH_WRITE;
								end
								OP_READ: begin
									bit_cnt   = '0;
									eep_phase = PH_READ;
									lines[PIN_DO] = 1'b0;
								end
								default: begin
									// erase is dropped silently while protected
									if (!protect) begin
										words[op_bits[ADDR_W-1:0]] = ERASED_WORD;
										lines[PIN_DO] = 1'b1;
									end
									eep_phase = PH_IDLE;
								end
							endcase
						end
					end
					PH_READ: begin
						lines[PIN_DO] = words[op_bits[ADDR_W-1:0]][WORD_BITS - 1 - bit_cnt[3:0]];
						bit_cnt = bit_cnt + 1'b1;
						if (bit_cnt >= WORD_BITS) begin
							bit_cnt = '0;
							op_bits = {OP_READ, op_bits[ADDR_W-1:0] + 6'd1};
						end
					end
					default: begin
						in_word = {in_word[WORD_BITS-2:0], din};
						bit_cnt = bit_cnt + 1'b1;
						if (bit_cnt >= WORD_BITS) begin
							if (!protect) begin
								if (op_bits[6])
									words[op_bits[ADDR_W-1:0]] = in_word;
								else
									fill_words(in_word);
							end
							lines[PIN_DO] = 1'b1;
							eep_phase = PH_IDLE;
						end
					end
				endcase
			end else begin
				lines[2:0] = v[2:0];
			end
		end else if (c == CMD_CTRL) begin
			// control byte: full reset keeps memory and the data latch
			if (v[CTRL_RESET]) begin
				en_q    = 1'b0;
				lines   = '0;
				lines[PIN_DO] = 1'b1;
				protect = 1'b1;
				model_restart();
			end else begin
				en_q = v[CTRL_ENABLE];
			end
		end
		r.enabled    = en_q;
		r.pin_status = {lines[PIN_CS], 1'b1, lines[PIN_DO]};
		return r;
	endfunction

	// drive one item, record its expected status on acceptance
	task automatic send_item(cmd_t c, logic [7:0] v, logic typed, eep_result_t typed_res);
		eep_result_t pred;
		int          gap;
		if (idle_mix && !calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = c;
		s_tdata  = v;
		do @(posedge clk); while (!s_tready);
		pred = model_item(c, v);
		pending.push_back(typed ? typed_res : pred);
		items_sent++;
		@(negedge clk);
	endtask

	// pin write with random filler in the unused value bits
	task automatic pins(logic cs, logic ck, logic di);
		logic [7:0] fill;
		fill = 8'($urandom_range(0, 255));
		fill[PIN_DI]  = di;
		fill[PIN_CLK] = ck;
		fill[PIN_CS]  = cs;
		send_item(CMD_PINS, fill, 1'b0, '0);
	endtask

	// one serial bit: clock low then high, sometimes a status poll after
	task automatic clock_in(logic di);
		pins(1'b1, 1'b0, di);
		pins(1'b1, 1'b1, di);
		if ($urandom_range(0, 7) == 0)
			send_item(CMD_STATUS, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	// hold the sender until every expected status has come back
	task automatic wait_drain();
		s_tvalid = 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat ($urandom_range(1, 8)) @(posedge clk);
		@(negedge clk);
	endtask

	// one framed bus command with random content, now and then cut short
	task automatic microwire_cmd();
		mw_op_t               op;
		logic [7:0]           opc;
		logic [WORD_BITS-1:0] data;
		logic [ADDR_W-1:0]    addr;
		logic [3:0]           junk;
		int                   pick;
		int                   n_op;
		int                   n_data;
		int                   n_read;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			op = MW_READ;
		else if (pick < 50)
			op = MW_WRITE;
		else if (pick < 62)
			op = MW_ERASE;
		else if (pick < 80)
			op = MW_EWEN;
		else if (pick < 90)
			op = MW_EWDS;
		else if (pick < 95)
			op = MW_WRAL;
		else
			op = MW_ERAL;
		case ($urandom_range(0, 3))
			0, 1:    addr = ADDR_W'($urandom_range(0, 3));
			2:       addr = ADDR_W'($urandom_range(0, WORD_COUNT - 1));
			default: addr = ADDR_W'(WORD_COUNT - 1);
		endcase
		case ($urandom_range(0, 3))
			0:       data = '0;
			1:       data = '1;
			default: data = WORD_BITS'($urandom_range(0, 65535));
		endcase
		junk = 4'($urandom_range(0, 15));
		case (op)
			MW_READ:  opc = {OP_READ, addr};
			MW_WRITE: opc = {OP_WRITE, addr};
			MW_ERASE: opc = {OP_ERASE, addr};
			MW_EWEN:  opc = {OP_SPECIAL, SP_EWEN, junk};
			MW_EWDS:  opc = {OP_SPECIAL, SP_EWDS, junk};
			MW_WRAL:  opc = {OP_SPECIAL, SP_WRAL, junk};
			default:  opc = {OP_SPECIAL, SP_ERAL, junk};
		endcase
		op_count[op]++;
		n_op   = 8;
		n_data = WORD_BITS;
		n_read = ($urandom_range(0, 3) == 0) ? 2 * WORD_BITS + $urandom_range(0, 4)
			: $urandom_range(1, WORD_BITS + 1);
		// a broken frame drops chip select mid-opcode or mid-data
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 1))
				n_op = $urandom_range(0, 7);
			else
				n_data = $urandom_range(0, WORD_BITS - 1);
		end
		pins(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		pins(1'b1, 1'b0, 1'b0);
		repeat ($urandom_range(0, 2)) clock_in(1'b0);
		clock_in(1'b1);
		for (int i = 7; i >= 8 - n_op; i--)
			clock_in(opc[i]);
		if (n_op == 8) begin
			if (op == MW_WRITE || op == MW_WRAL) begin
				for (int i = WORD_BITS - 1; i >= WORD_BITS - n_data; i--)
					clock_in(data[i]);
			end else if (op == MW_READ) begin
				repeat (n_read) clock_in(1'($urandom_range(0, 1)));
			end
		end
		if ($urandom_range(0, 2) == 0)
			send_item(CMD_STATUS, 8'($urandom_range(0, 255)), 1'b0, '0);
		pins(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// result receiver with random stall bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_mix && !calm && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each result item with the oldest expectation
	always @(posedge clk) begin : check_result
		eep_result_t want;
		eep_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[3:0];
			results_seen++;
			if (pending.size() == 0) begin
				$error("result with nothing expected: pin_status %0h enabled %0b",
					got.pin_status, got.enabled);
				err_count++;
			end else begin
				want = pending.pop_front();
				if (got.pin_status !== want.pin_status) begin
					$error("pin_status: expected %0h, got %0h", want.pin_status, got.pin_status);
					err_count++;
				end
				if (got.enabled !== want.enabled) begin
					$error("enabled: expected %0b, got %0b", want.enabled, got.enabled);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout after %0d idle cycles", quiet);
				$display("microwire_serial_eeprom_64x16 regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int   k;
		cmd_t nc;
		logic [7:0] nv;

		// predictor at reset: idle, protected, all words erased
		model_restart();
		in_word = '0;
		protect = 1'b1;
		lines   = '0;
		lines[PIN_DO] = 1'b1;
		en_q    = 1'b0;
		fill_words(ERASED_WORD);
		foreach (op_count[i])
			op_count[i] = 0;

		// directed rows: status after reset, control extremes, select and clock edges
		plan[0]  = '{CMD_STATUS, 8'h00, 1'b1, 4'b0011};
		plan[1]  = '{CMD_STATUS, 8'hFF, 1'b1, 4'b0011};
		plan[2]  = '{CMD_CTRL,   8'h08, 1'b1, 4'b1011};
		plan[3]  = '{CMD_CTRL,   8'hF7, 1'b1, 4'b0011};
		plan[4]  = '{CMD_CTRL,   8'h7F, 1'b1, 4'b1011};
		plan[5]  = '{CMD_CTRL,   8'h00, 1'b1, 4'b0011};
		plan[6]  = '{CMD_CTRL,   8'h08, 1'b1, 4'b1011};
		plan[7]  = '{CMD_CTRL,   8'h80, 1'b1, 4'b0011};
		plan[8]  = '{CMD_PINS,   8'h00, 1'b1, 4'b0011};
		plan[9]  = '{CMD_PINS,   8'h06, 1'b1, 4'b0111};
		plan[10] = '{CMD_PINS,   8'h07, 1'b1, 4'b0111};
		plan[11] = '{CMD_PINS,   8'h04, 1'b1, 4'b0111};
		plan[12] = '{CMD_PINS,   8'hFF, 1'b1, 4'b0111};
		plan[13] = '{CMD_PINS,   8'hF8, 1'b1, 4'b0011};
		plan[14] = '{CMD_CTRL,   8'h88, 1'b1, 4'b0011};
		plan[15] = '{CMD_PINS,   8'h03, 1'b0, 4'b0000};
		plan[16] = '{CMD_PINS,   8'h05, 1'b0, 4'b0000};
		plan[17] = '{CMD_STATUS, 8'h00, 1'b0, 4'b0000};
		plan[18] = '{CMD_PINS,   8'h00, 1'b1, 4'b0011};

		// reset
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < PLAN_ROWS; i++)
			send_item(plan[i].c, plan[i].v, plan[i].typed, plan[i].want);
		wait_drain();

		// random part: framed commands with noise in between
		while (items_sent < ITEM_GOAL) begin
			if (items_sent > ITEM_GOAL * 9 / 10)
				calm = 1'b1;
			idle_mix = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					k = $urandom_range(0, 2);
					nc = cmd_t'(k);
					nv = 8'($urandom_range(0, 255));
					if (nc == CMD_CTRL && $urandom_range(0, 7) != 0)
						nv[CTRL_RESET] = 1'b0;
					send_item(nc, nv, 1'b0, '0);
				end
			end
			microwire_cmd();
			if ($urandom_range(0, 14) == 0)
				wait_drain();
		end

		// drain and settle
		s_tvalid = 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending.size() != 0) begin
			$error("%0d expected results never arrived", pending.size());
			err_count++;
		end

		$display("ran %0d items, %0d results checked, with idle bursts, stalls and cut frames",
			items_sent, results_seen);
		$display("commands: read %0d write %0d erase %0d ewen %0d ewds %0d wral %0d eral %0d",
			op_count[MW_READ], op_count[MW_WRITE], op_count[MW_ERASE], op_count[MW_EWEN],
			op_count[MW_EWDS], op_count[MW_WRAL], op_count[MW_ERAL]);
		if (err_count == 0)
			$display("microwire_serial_eeprom_64x16 regression: pass");
		else
			$display("microwire_serial_eeprom_64x16 regression: fail");
		$finish;
	end

endmodule
